@@ rtl/fsad_pkg.sv @@
// Package with shared constants and types for the five-symbol arithmetic decoder.
`timescale 1ns / 1ps
package fsad_pkg;
  localparam int unsigned STREAM_DEPTH_DEF = 4096;
  localparam int unsigned CFG_W   = 13;
  localparam int unsigned POS_W   = 32;
  localparam int unsigned FREQ_W  = 32;

  localparam logic [1:0] CMD_LOAD   = 2'd0;
  localparam logic [1:0] CMD_START  = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_TOTAL   = 3'd2;
  localparam logic [2:0] ST_NOSYM   = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  localparam logic [63:0] TOP_VALUE      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] QUARTER        = 64'h2000_0000_0000_0000;
  localparam logic [63:0] HALF_RANGE     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] THREE_QUARTERS = 64'h6000_0000_0000_0000;
  localparam logic [32:0] FREQ_TOTAL     = 33'h1_0000_0000 >> 1;
  localparam logic [31:0] POS_MAX        = 32'hFFFF_FFFF;

  // Request and reply between the sequencer and the bit reader.
  typedef struct packed {
    logic        req;
    logic [31:0] pos;
  } bit_req_t;

  typedef struct packed {
    logic        done;
    logic        bit_val;
  } bit_rsp_t;
endpackage

@@ rtl/fsad_bit_reader.sv @@
// Stream byte store with a single-bit read path.
`timescale 1ns / 1ps
module fsad_bit_reader
  import fsad_pkg::*;
#(
  parameter int unsigned STREAM_DEPTH = STREAM_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [11:0]         wr_addr,
  input  logic [7:0]          wr_data,
  input  logic [CFG_W-1:0]    stream_length,
  input  bit_req_t            rd,
  output bit_rsp_t            rsp
);
  localparam int unsigned AW = $clog2(STREAM_DEPTH);

  logic [7:0] store [STREAM_DEPTH];
  logic [7:0] rdata_r;
  logic       valid_r, inrange_r;
  logic [2:0] sel_r;
  logic [28:0] byte_idx;
  logic        inrange;

  assign byte_idx = rd.pos[31:3];
  assign inrange  = ({16'd0, byte_idx} < {32'd0, stream_length}) &&
                    ({16'd0, byte_idx} < 45'(STREAM_DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en && ({20'd0, wr_addr} < 32'(STREAM_DEPTH)))
      store[AW'(wr_addr)] <= wr_data;
    rdata_r <= store[byte_idx[AW-1:0]];
    sel_r   <= rd.pos[2:0];
    inrange_r <= inrange;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= rd.req;
  end

  assign rsp.done    = valid_r;
  assign rsp.bit_val = inrange_r & rdata_r[3'd7 - sel_r];
endmodule

@@ rtl/five_symbol_arithmetic_decoder.sv @@
// Top level of the five-symbol 63-bit integer arithmetic decoder.
`timescale 1ns / 1ps
//  channel | dir | ports                       | word
//  in_     | in  | in_tvalid/tready/tdata     | command, address, byte, five freqs
//  out_    | out | out_tvalid/tready/tdata    | symbol, status, stream_pos
//  cfg_    | in  | cfg_valid/ready/data       | stream_length
// One word at a time. A start fills the code with 63 bits and a decode reads
// a renormalization bit for each shift (up to 63 bits): every bit comes
// through the registered read port of the byte store. The 31-step division
// runs one quotient bit a cycle. Reset is synchronous; a stalled output
// holds its word and blocks new input until taken.
module five_symbol_arithmetic_decoder
  import fsad_pkg::*;
#(
  parameter int unsigned STREAM_DEPTH = STREAM_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // command[1:0], byte_address[13:2], byte_value[21:14], freq_sym0..4 [181:22], pad
  input  logic [183:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // symbol[2:0], status[5:3], stream_pos[37:6], pad
  output logic [39:0]  out_tdata,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);
  localparam logic [3:0] S_IDLE=4'd0, S_LOAD=4'd1, S_FILL=4'd2, S_WAIT=4'd3,
    S_CHK=4'd4, S_DIV=4'd5, S_SRCH=4'd6, S_MUL=4'd7, S_UPD=4'd8, S_REN=4'd9,
    S_RWAIT=4'd10, S_OUT=4'd11;

  logic [3:0]  state_r, state_nxt;
  logic [CFG_W-1:0] len_r;
  logic [63:0] low_r, high_r, code_r;
  logic [31:0] pos_r;
  logic [1:0]  cmd_r;
  logic [11:0] addr_r;
  logic [7:0]  bval_r;
  logic [31:0] freq_r [5];
  logic [63:0] width_r, rem_r;
  logic [30:0] quot_r;
  logic [5:0]  cnt_r;
  logic [2:0]  sym_r, status_r;
  logic [32:0] cum_lo_r, cum_hi_r;
  logic [63:0] off_lo_r, off_hi_r;
  logic        fill_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  bit_req_t rd;
  bit_rsp_t rsp;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) len_r <= CFG_W'(1);
    else if (cfg_valid) len_r <= cfg_data;
  end

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;

  fsad_bit_reader #(.STREAM_DEPTH(STREAM_DEPTH)) u_rd (
    .clk, .rst_n,
    .wr_en(state_r == S_LOAD), .wr_addr(addr_r), .wr_data(bval_r),
    .stream_length(len_r), .rd, .rsp
  );

  assign rd.req = (state_r == S_FILL) || (state_r == S_REN);
  assign rd.pos = pos_r;

  logic [34:0] total;
  logic        anyzero;
  logic [64:0] rem_sh;
  logic [32:0] cum_next;
  logic [63:0] mul_lo_v, mul_hi_v;
  logic [63:0] nlow, nhigh, sub;
  logic        ren_go;

  always_comb begin
    total = '0;
    anyzero = 1'b0;
    for (int i = 0; i < 5; i++) begin
      total = total + 35'(freq_r[i]);
      anyzero = anyzero | (freq_r[i] == '0);
    end
  end

  assign rem_sh   = {rem_r, 1'b1};
  assign cum_next = cum_hi_r + {1'b0, freq_r[sym_r]};
  // floor(w*c/2^31) split as (w>>31)*c + ((w mod 2^31)*c >> 31); both offsets are registered together in S_MUL.
  assign mul_lo_v = 64'(width_r[63:31] * cum_lo_r) +
                    64'((64'(width_r[30:0]) * 64'(cum_lo_r)) >> 31);
  assign mul_hi_v = 64'(width_r[63:31] * cum_hi_r) +
                    64'((64'(width_r[30:0]) * 64'(cum_hi_r)) >> 31);

  always_comb begin
    ren_go = 1'b1;
    sub = '0;
    if (high_r < HALF_RANGE) sub = '0;
    else if (low_r >= HALF_RANGE) sub = HALF_RANGE;
    else if (low_r >= QUARTER && high_r < THREE_QUARTERS) sub = QUARTER;
    else ren_go = 1'b0;
    nlow  = (low_r - sub) << 1;
    nhigh = ((high_r - sub) << 1) | 64'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      low_r <= '0; high_r <= TOP_VALUE; code_r <= '0; pos_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (in_tvalid && in_tready) begin
          cmd_r  <= in_tdata[1:0];
          addr_r <= in_tdata[13:2];
          bval_r <= in_tdata[21:14];
          for (int i = 0; i < 5; i++) freq_r[i] <= in_tdata[22+32*i +: 32];
          sym_r <= '0; status_r <= ST_OK;
          unique case (in_tdata[1:0])
            CMD_LOAD:   state_r <= S_LOAD;
            CMD_START: begin
              low_r <= '0; high_r <= TOP_VALUE; code_r <= '0; pos_r <= '0;
              cnt_r <= '0; fill_r <= 1'b1; state_r <= S_FILL;
            end
            CMD_DECODE: state_r <= S_CHK;
            default:    state_r <= S_OUT;
          endcase
        end
        S_LOAD: state_r <= S_OUT;
        S_FILL, S_REN: state_r <= S_RWAIT;
        S_RWAIT: if (rsp.done) begin
          code_r <= {code_r[62:0], rsp.bit_val};
          if (pos_r != POS_MAX) pos_r <= pos_r + 32'd1;
          if (fill_r) begin
            cnt_r <= cnt_r + 6'd1;
            state_r <= (cnt_r == 6'd62) ? S_OUT : S_FILL;
          end else state_r <= S_UPD;
        end
        S_CHK: begin
          fill_r <= 1'b0;
          width_r <= high_r - low_r + 64'd1;
          rem_r <= code_r - low_r;
          quot_r <= '0; cnt_r <= '0;
          if (anyzero) begin status_r <= ST_ZERO; state_r <= S_OUT; end
          else if (total != FREQ_TOTAL || code_r < low_r || code_r > high_r) begin
            status_r <= ST_TOTAL; state_r <= S_OUT;
          end else state_r <= S_DIV;
        end
        S_DIV: begin
          if ({1'b0, rem_sh[63:0]} >= {1'b0, width_r} || rem_sh[64]) begin
            rem_r <= rem_sh[63:0] - width_r;
            quot_r <= {quot_r[29:0], 1'b1};
          end else begin
            rem_r <= rem_sh[63:0];
            quot_r <= {quot_r[29:0], 1'b0};
          end
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'd30) begin
            sym_r <= '0; cum_lo_r <= '0; cum_hi_r <= '0; state_r <= S_SRCH;
          end
        end
        S_SRCH: begin
          if ({2'b0, quot_r} < cum_next) begin
            cum_hi_r <= cum_next; state_r <= S_MUL;
          end else if (sym_r == 3'd4) begin
            sym_r <= '0; status_r <= ST_NOSYM; state_r <= S_OUT;
          end else begin
            cum_hi_r <= cum_next; cum_lo_r <= cum_next; sym_r <= sym_r + 3'd1;
          end
        end
        S_MUL: begin
          off_lo_r <= mul_lo_v; off_hi_r <= mul_hi_v;
          cnt_r <= '0; state_r <= S_UPD; fill_r <= 1'b1;
        end
        S_UPD: begin
          if (fill_r) begin
            fill_r <= 1'b0;
            if (off_hi_r <= off_lo_r) begin
              sym_r <= '0; status_r <= ST_EMPTY; state_r <= S_OUT;
            end else begin
              high_r <= low_r + off_hi_r - 64'd1;
              low_r  <= low_r + off_lo_r;
            end
          end else if (ren_go) begin
            low_r <= nlow; high_r <= nhigh; code_r <= code_r - sub;
            state_r <= S_REN;
          end else state_r <= S_OUT;
        end
        S_OUT: if (!out_valid_r) begin
          out_valid_r <= 1'b1;
          out_data_r  <= {2'b0, pos_r, status_r, sym_r};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_tready) else $error("accept while busy");
  a_sym_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r[2:0] == 3'd0 || out_data_r[5:3] == ST_OK))
    else $error("symbol with error status");
  a_pos_mono: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_RWAIT && state_r != S_IDLE && $past(cmd_r) == CMD_DECODE
     && $past(rsp.done)) |-> (pos_r >= $past(pos_r))) else $error("position drop");
endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the five-symbol arithmetic decoder.
`timescale 1ns / 1ps
module tb;
  import fsad_pkg::*;

  localparam int unsigned DEPTH       = STREAM_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [31:0] F_HALF      = 32'h8000_0000;

  typedef struct {
    logic [1:0]  cmd;
    logic [11:0] addr;
    logic [7:0]  bval;
    logic [31:0] freq [5];
  } cmd_word_t;

  typedef struct {
    logic [2:0]  symbol;
    logic [2:0]  status;
    logic [31:0] pos;
  } dec_result_t;

  typedef struct {
    cmd_word_t   word;
    bit          typed;
    logic [2:0]  symbol;
    logic [2:0]  status;
  } dir_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [183:0]       in_tdata;
  logic               out_tvalid;
  logic               out_tready;
  logic [39:0]        out_tdata;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CFG_W-1:0]   cfg_data;

  five_symbol_arithmetic_decoder dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow of the decoder state.
  logic [63:0]  m_low, m_high, m_code;
  logic [31:0]  m_pos;
  logic [12:0]  m_len;
  logic [7:0]   m_store [DEPTH];
  bit           m_written [DEPTH];

  dec_result_t  pending_results [$];
  dir_row_t     dir_rows [$];
  int           errors;
  int           cycles;
  int           burst_left;
  bit           hold_request;
  int           n_ok, n_fail, n_load, n_start;

  initial begin
    clk = 1'b0;
    cycles = 0;
    forever begin
      #5 clk = ~clk;
      if (clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
          $display("timeout after %0d cycles", cycles);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic logic [183:0] pack_word(cmd_word_t w);
    return {2'b00, w.freq[4], w.freq[3], w.freq[2], w.freq[1], w.freq[0],
            w.bval, w.addr, w.cmd};
  endfunction

  function automatic logic read_bit();
    logic [31:0] idx;
    logic        b;
    idx = m_pos >> 3;
    b = 1'b0;
    if (idx < m_len && idx < DEPTH) b = m_store[idx][7 - m_pos[2:0]];
    if (m_pos != POS_MAX) m_pos++;
    return b;
  endfunction

  function automatic logic [63:0] scale_code(logic [63:0] d, logic [63:0] w);
    logic [63:0] rem, quot;
    rem = d - 1;
    quot = 0;
    for (int i = 0; i < 31; i++) begin
      rem = (rem << 1) | 64'd1;
      quot = quot << 1;
      if (rem >= w) begin
        rem -= w;
        quot[0] = 1'b1;
      end
    end
    return quot;
  endfunction

  function automatic logic [63:0] mul_shift31(logic [63:0] w, logic [63:0] c);
    return (w >> 31) * c + (((w & 64'h7FFF_FFFF) * c) >> 31);
  endfunction

  function automatic logic [2:0] decode_step(cmd_word_t w, output logic [2:0] sym);
    logic [34:0] total;
    logic [63:0] width, scaled, cum_lo, cum_hi, off_lo, off_hi, sub;
    int          s;
    sym = 3'd0;
    total = 0;
    for (int i = 0; i < 5; i++) begin
      if (w.freq[i] == 0) return ST_ZERO;
      total += w.freq[i];
    end
    if (total != FREQ_TOTAL || m_code < m_low || m_code > m_high) return ST_TOTAL;
    width = m_high - m_low + 1;
    scaled = scale_code(m_code - m_low + 1, width);
    cum_lo = 0;
    cum_hi = 0;
    for (s = 0; s < 5; s++) begin
      cum_hi += w.freq[s];
      if (scaled < cum_hi) break;
      cum_lo = cum_hi;
    end
    if (s == 5) return ST_NOSYM;
    off_lo = mul_shift31(width, cum_lo);
    off_hi = mul_shift31(width, cum_hi);
    if (off_hi <= off_lo) return ST_EMPTY;
    m_high = m_low + off_hi - 1;
    m_low += off_lo;
    forever begin
      if (m_high < HALF_RANGE) sub = 0;
      else if (m_low >= HALF_RANGE) sub = HALF_RANGE;
      else if (m_low >= QUARTER && m_high < THREE_QUARTERS) sub = QUARTER;
      else break;
      m_code -= sub;
      m_low = (m_low - sub) << 1;
      m_high = ((m_high - sub) << 1) | 64'd1;
      m_code = (m_code << 1) | 64'(read_bit());
    end
    sym = 3'(s);
    return ST_OK;
  endfunction

  function automatic dec_result_t decoder_model(cmd_word_t w);
    dec_result_t r;
    r.symbol = 0;
    r.status = ST_OK;
    case (w.cmd)
      CMD_LOAD: begin
        m_store[w.addr] = w.bval;
        m_written[w.addr] = 1'b1;
        n_load++;
      end
      CMD_START: begin
        m_low = 0;
        m_high = TOP_VALUE;
        m_code = 0;
        m_pos = 0;
        for (int i = 0; i < 63; i++) m_code = (m_code << 1) | 64'(read_bit());
        n_start++;
      end
      CMD_DECODE: begin
        r.status = decode_step(w, r.symbol);
        if (r.status == ST_OK) n_ok++;
        else n_fail++;
      end
      default: ;
    endcase
    r.pos = m_pos;
    return r;
  endfunction

  task automatic send_word(cmd_word_t w, bit typed = 0, logic [2:0] sym = 0,
                           logic [2:0] st = 0);
    dec_result_t r;
    in_tvalid <= 1'b1;
    in_tdata  <= pack_word(w);
    do @(posedge clk); while (!in_tready);
    r = decoder_model(w);
    if (typed) begin
      r.symbol = sym;
      r.status = st;
    end
    pending_results.push_back(r);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  // The sender stops offering a word before it waits for the results.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_length(logic [CFG_W-1:0] len);
    wait_drained();
    repeat (20) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    m_len = len;
  endtask

  function automatic cmd_word_t make_word(logic [1:0] cmd, logic [11:0] addr = 0,
      logic [7:0] bval = 0, logic [31:0] f0 = 0, logic [31:0] f1 = 0,
      logic [31:0] f2 = 0, logic [31:0] f3 = 0, logic [31:0] f4 = 0);
    cmd_word_t w;
    w.cmd = cmd;
    w.addr = addr;
    w.bval = bval;
    w.freq[0] = f0; w.freq[1] = f1; w.freq[2] = f2; w.freq[3] = f3; w.freq[4] = f4;
    return w;
  endfunction

  function automatic void add_row(cmd_word_t w, bit typed = 0, logic [2:0] sym = 0,
                                  logic [2:0] st = 0);
    dir_row_t r;
    r.word = w;
    r.typed = typed;
    r.symbol = sym;
    r.status = st;
    dir_rows.push_back(r);
  endfunction

  // Loads any unwritten byte that the next start or decode might read.
  task automatic fill_ahead(logic [31:0] from_bit);
    int first, last;
    first = from_bit >> 3;
    last = first + 9;
    for (int b = first; b <= last; b++)
      if (b < m_len && b < DEPTH && !m_written[b])
        send_word(make_word(CMD_LOAD, 12'(b), 8'($urandom)));
  endtask

  function automatic cmd_word_t random_decode(bit broken);
    cmd_word_t   w;
    logic [31:0] cut [6];
    logic [31:0] t;
    w = make_word(CMD_DECODE, 12'($urandom), 8'($urandom));
    // Four distinct cut points inside the total give five nonzero frequencies.
    cut[0] = 0;
    cut[5] = F_HALF;
    do begin
      for (int i = 1; i < 5; i++)
        cut[i] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) << $urandom_range(0, 24)
                                             : $urandom_range(1, 32'h7FFF_FFFF);
      for (int i = 1; i < 5; i++)
        for (int j = 1; j < 5 - i + 1; j++)
          if (cut[j] > cut[j + 1]) begin
            t = cut[j]; cut[j] = cut[j + 1]; cut[j + 1] = t;
          end
    end while (cut[1] == 0 || cut[1] == cut[2] || cut[2] == cut[3] || cut[3] == cut[4]
               || cut[4] >= F_HALF);
    for (int i = 0; i < 5; i++) w.freq[i] = cut[i + 1] - cut[i];
    if (broken) begin
      case ($urandom_range(0, 2))
        0: w.freq[$urandom_range(0, 4)] = 0;
        1: w.freq[$urandom_range(0, 4)] += $urandom_range(1, 1000);
        default: w.freq[$urandom_range(0, 4)] = $urandom;
      endcase
    end
    return w;
  endfunction

  // Result side: compare each word, stall on a random pattern or a long hold.
  initial begin
    dec_result_t want;
    int          hold_left;
    bit          slow;
    out_tready = 1'b0;
    hold_left = 0;
    slow = 0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          $display("unexpected result word at cycle %0d", cycles);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_tdata[2:0] !== want.symbol) report("symbol", out_tdata[2:0], want.symbol);
          if (out_tdata[5:3] !== want.status) report("status", out_tdata[5:3], want.status);
          if (out_tdata[37:6] !== want.pos) report("stream_pos", out_tdata[37:6], want.pos);
        end
      end
      if (hold_request) begin
        hold_request = 0;
        hold_left = 3000;
      end
      if ($urandom_range(0, 63) == 0) slow = ~slow;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= slow ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
      end
    end
  end

  initial begin
    logic [12:0] lengths [5];
    int          pick;
    errors = 0;
    n_ok = 0; n_fail = 0; n_load = 0; n_start = 0;
    hold_request = 0;
    burst_left = 10;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    m_low = 0;
    m_high = TOP_VALUE;
    m_code = 0;
    m_pos = 0;
    m_len = 1;
    for (int i = 0; i < DEPTH; i++) begin
      m_store[i] = 0;
      m_written[i] = 0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (5) @(posedge clk);

    add_row(make_word(CMD_LOAD, 12'd0, 8'hA5));
    add_row(make_word(CMD_DECODE, 12'hFFF, 8'hFF, 32'h0800_0000, 32'h1000_0000,
                      32'h1800_0000, 32'h2000_0000, 32'h2800_0000));
    add_row(make_word(CMD_START));
    add_row(make_word(CMD_DECODE, 0, 0, 0, 32'h2000_0000, 32'h2000_0000,
                      32'h2000_0000, 32'h2000_0000), 1, 3'd0, ST_ZERO);
    add_row(make_word(CMD_DECODE, 0, 0, F_HALF, 0, 0, 0, 0), 1, 3'd0, ST_ZERO);
    add_row(make_word(CMD_DECODE, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 3'd0, ST_TOTAL);
    add_row(make_word(CMD_DECODE, 0, 0, 32'h1999_9999, 32'h1999_9999, 32'h1999_9999,
                      32'h1999_9999, 32'h1999_999C));
    add_row(make_word(CMD_DECODE, 0, 0, 1, 1, 1, 1, F_HALF - 4));
    add_row(make_word(CMD_DECODE, 0, 0, F_HALF - 4, 1, 1, 1, 1));
    add_row(make_word(CMD_UNUSED, 12'hFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1, 3'd0, ST_OK);
    add_row(make_word(CMD_LOAD, 12'hFFF, 8'hFF));
    add_row(make_word(CMD_LOAD, 12'd0, 8'h00));
    add_row(make_word(CMD_START));
    add_row(make_word(CMD_DECODE, 0, 0, 1, 1, F_HALF - 3, 0, 1), 1, 3'd0, ST_ZERO);
    add_row(make_word(CMD_DECODE, 0, 0, 1, 1, 1, F_HALF - 4, 1));
    add_row(make_word(CMD_LOAD, 12'd0, 8'hFF));
    add_row(make_word(CMD_START));
    add_row(make_word(CMD_DECODE, 0, 0, 1, 1, 1, 1, F_HALF - 4));
    foreach (dir_rows[i])
      send_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].symbol, dir_rows[i].status);

    lengths[0] = 13'd4096;
    lengths[1] = 13'd0;
    lengths[2] = 13'($urandom_range(2, 4095));
    lengths[3] = 13'd13;
    lengths[4] = 13'd1;
    for (int ph = 0; ph < 5; ph++) begin
      write_length(lengths[ph]);
      fill_ahead(0);
      send_word(make_word(CMD_START));
      for (int n = 0; n < 80; n++) begin
        if (ph == 1 && n == 20) hold_request = 1;
        if (ph == 2 && n == 40) wait_drained();
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          fill_ahead(0);
          send_word(make_word(CMD_START));
        end else if (pick < 16) begin
          send_word(make_word(CMD_LOAD, 12'($urandom), 8'($urandom)));
        end else if (pick < 20) begin
          send_word(make_word(CMD_UNUSED, 12'($urandom), 8'($urandom), $urandom,
                              $urandom, $urandom, $urandom, $urandom));
        end else begin
          fill_ahead(m_pos);
          send_word(random_decode(pick >= 85));
        end
      end
    end

    wait_drained();
    repeat (300) @(posedge clk);
    $display("covered %0d loads, %0d starts, %0d good decodes, %0d rejected decodes",
             n_load, n_start, n_ok, n_fail);
    $display("stream lengths 0, 1, 13, 4096 and one random length; %0d mismatches", errors);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
